// ===== rtl/core/cdts_pkg.sv =====
// ----------------------------------------------------------------------------
// cdts_pkg
// Shared types, codes and helpers for the clock date/time setting unit.
// ----------------------------------------------------------------------------
package cdts_pkg;

	localparam logic [3:0] KEY_A = 4'd0;
	localparam logic [3:0] KEY_B = 4'd1;
	localparam logic [3:0] KEY_C = 4'd2;
	localparam logic [3:0] KEY_D = 4'd3;

	localparam logic [7:0] BLINK_RESET = 8'd10;
	localparam logic [3:0] MONTH_TOP   = 4'd12;
	localparam logic [4:0] HOUR_TOP    = 5'd23;
	localparam logic [5:0] MINSEC_TOP  = 6'd59;

	typedef enum logic [2:0] {
		MODE_SHOW  = 3'd0,
		MODE_YEAR  = 3'd1,
		MODE_MONTH = 3'd2,
		MODE_DAY   = 3'd3,
		MODE_HOUR  = 3'd4,
		MODE_MIN   = 3'd5,
		MODE_SEC   = 3'd6
	} mode_t;

	typedef struct packed {
		logic       key_valid;
		logic [3:0] key_code;
		logic [5:0] now_sec;
		logic [5:0] now_min;
		logic [4:0] now_hour;
		logic [4:0] now_day;
		logic [3:0] now_month;
		logic [7:0] now_year;
	} item_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       blink_on;
		logic [5:0] edit_sec;
		logic [5:0] edit_min;
		logic [4:0] edit_hour;
		logic [4:0] edit_day;
		logic [3:0] edit_month;
		logic [7:0] edit_year;
		logic       commit;
	} result_t;

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic [7:0] year);
		logic [4:0] len;
		begin
			len = 5'd31;
			if (month == 4'd2) begin
				len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
			end else if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
				len = 5'd30;
			end
			return len;
		end
	endfunction

endpackage

// ===== rtl/core/cdts_in_stage.sv =====
// ----------------------------------------------------------------------------
// cdts_in_stage
// Input register: captures one tick word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module cdts_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  cdts_pkg::item_t item,
	input  logic           take,
	output logic           valid_s1,
	output cdts_pkg::item_t item_s1
);

	logic accept;

	assign in_stall = valid_s1 && !take;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== rtl/core/cdts_core.sv =====
// ----------------------------------------------------------------------------
// cdts_core
// Setting state machine, edit registers, blink timer and result register.
// ----------------------------------------------------------------------------
module cdts_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_data,
	input  logic             valid_s1,
	input  cdts_pkg::item_t  item_s1,
	output logic             take,
	output logic             out_valid,
	input  logic             out_stall,
	output cdts_pkg::result_t res_q
);

	cdts_pkg::mode_t mode_q, mode_d;
	logic [7:0] period_q;
	logic [7:0] blink_cnt_q, blink_cnt_d, blink_dec;
	logic       blink_flag_q, blink_flag_d;
	logic [5:0] sec_q, sec_d;
	logic [5:0] min_q, min_d;
	logic [4:0] hour_q, hour_d;
	logic [4:0] day_q, day_d;
	logic [3:0] month_q, month_d;
	logic [7:0] year_q, year_d;
	logic       commit_d;
	logic       key_ok;
	logic       up;
	logic [4:0] len;
	logic       out_valid_q;

	assign out_valid = out_valid_q;
	assign take      = valid_s1 && (!out_valid_q || !out_stall);
	assign key_ok    = item_s1.key_valid && (item_s1.key_code <= cdts_pkg::KEY_D);
	assign up        = (item_s1.key_code == cdts_pkg::KEY_B);
	assign len       = cdts_pkg::month_len(month_q, year_q);
	assign blink_dec = blink_cnt_q - 8'd1;

	// next mode
	always_comb begin
		mode_d = mode_q;
		if (key_ok) begin
			if (mode_q == cdts_pkg::MODE_SHOW) begin
				if (item_s1.key_code == cdts_pkg::KEY_A) begin
					mode_d = cdts_pkg::MODE_YEAR;
				end
			end else if (item_s1.key_code == cdts_pkg::KEY_D) begin
				mode_d = cdts_pkg::MODE_SHOW;
			end else if (item_s1.key_code == cdts_pkg::KEY_A) begin
				case (mode_q)
					cdts_pkg::MODE_YEAR:  mode_d = cdts_pkg::MODE_MONTH;
					cdts_pkg::MODE_MONTH: mode_d = cdts_pkg::MODE_DAY;
					cdts_pkg::MODE_DAY:   mode_d = cdts_pkg::MODE_HOUR;
					cdts_pkg::MODE_HOUR:  mode_d = cdts_pkg::MODE_MIN;
					cdts_pkg::MODE_MIN:   mode_d = cdts_pkg::MODE_SEC;
					default:              mode_d = cdts_pkg::MODE_SHOW;
				endcase
			end
		end
	end

	// blink timer
	always_comb begin
		blink_cnt_d  = blink_cnt_q;
		blink_flag_d = blink_flag_q;
		if (mode_q == cdts_pkg::MODE_SHOW) begin
			blink_cnt_d = period_q;
		end else if (blink_dec == 8'd0) begin
			blink_flag_d = !blink_flag_q;
			blink_cnt_d  = period_q;
		end else begin
			blink_cnt_d = blink_dec;
		end
	end

	// edit fields and commit
	always_comb begin
		sec_d    = sec_q;
		min_d    = min_q;
		hour_d   = hour_q;
		day_d    = day_q;
		month_d  = month_q;
		year_d   = year_q;
		commit_d = 1'b0;
		if (key_ok) begin
			if (mode_q == cdts_pkg::MODE_SHOW) begin
				if (item_s1.key_code == cdts_pkg::KEY_A) begin
					year_d = item_s1.now_year;
				end
			end else if (item_s1.key_code == cdts_pkg::KEY_A) begin
				case (mode_q)
					cdts_pkg::MODE_YEAR:  month_d = item_s1.now_month;
					cdts_pkg::MODE_MONTH: day_d = (item_s1.now_day > len) ? len : item_s1.now_day;
					cdts_pkg::MODE_DAY:   hour_d = item_s1.now_hour;
					cdts_pkg::MODE_HOUR:  min_d = item_s1.now_min;
					cdts_pkg::MODE_MIN:   sec_d = item_s1.now_sec;
					default:              commit_d = 1'b1;
				endcase
			end else if (item_s1.key_code != cdts_pkg::KEY_D) begin
				case (mode_q)
					cdts_pkg::MODE_YEAR: begin
						year_d = up ? year_q + 8'd1 : year_q - 8'd1;
					end
					cdts_pkg::MODE_MONTH: begin
						if (up) begin
							month_d = (month_q >= cdts_pkg::MONTH_TOP) ? 4'd1 : month_q + 4'd1;
						end else begin
							month_d = (month_q <= 4'd1) ? cdts_pkg::MONTH_TOP : month_q - 4'd1;
						end
					end
					cdts_pkg::MODE_DAY: begin
						if (up) begin
							day_d = (day_q >= len) ? 5'd1 : day_q + 5'd1;
						end else begin
							day_d = (day_q <= 5'd1) ? len : day_q - 5'd1;
						end
					end
					cdts_pkg::MODE_HOUR: begin
						if (up) begin
							hour_d = (hour_q >= cdts_pkg::HOUR_TOP) ? 5'd0 : hour_q + 5'd1;
						end else begin
							hour_d = (hour_q == 5'd0) ? cdts_pkg::HOUR_TOP : hour_q - 5'd1;
						end
					end
					cdts_pkg::MODE_MIN: begin
						if (up) begin
							min_d = (min_q >= cdts_pkg::MINSEC_TOP) ? 6'd0 : min_q + 6'd1;
						end else begin
							min_d = (min_q == 6'd0) ? cdts_pkg::MINSEC_TOP : min_q - 6'd1;
						end
					end
					default: begin
						if (up) begin
							sec_d = (sec_q >= cdts_pkg::MINSEC_TOP) ? 6'd0 : sec_q + 6'd1;
						end else begin
							sec_d = (sec_q == 6'd0) ? cdts_pkg::MINSEC_TOP : sec_q - 6'd1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= cdts_pkg::BLINK_RESET;
		end else if (cfg_we) begin
			period_q <= (cfg_data == 8'd0) ? 8'd1 : cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= cdts_pkg::MODE_SHOW;
			blink_cnt_q  <= cdts_pkg::BLINK_RESET;
			blink_flag_q <= 1'b0;
			sec_q        <= 6'd0;
			min_q        <= 6'd0;
			hour_q       <= 5'd0;
			day_q        <= 5'd0;
			month_q      <= 4'd0;
			year_q       <= 8'd0;
		end else if (take) begin
			mode_q       <= mode_d;
			blink_cnt_q  <= blink_cnt_d;
			blink_flag_q <= blink_flag_d;
			sec_q        <= sec_d;
			min_q        <= min_d;
			hour_q       <= hour_d;
			day_q        <= day_d;
			month_q      <= month_d;
			year_q       <= year_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.mode       <= mode_d;
			res_q.blink_on   <= blink_flag_d;
			res_q.edit_sec   <= sec_d;
			res_q.edit_min   <= min_d;
			res_q.edit_hour  <= hour_d;
			res_q.edit_day   <= day_d;
			res_q.edit_month <= month_d;
			res_q.edit_year  <= year_d;
			res_q.commit     <= commit_d;
		end
	end

endmodule

// ===== rtl/core/clock_date_time_setting_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// clock_date_time_setting_fsm_unit
// Date/time setting state machine for a digital clock, one word per tick.
// ----------------------------------------------------------------------------
// Each input word is one polling tick with an optional key and the running
// clock's date and time; each produces exactly one result word with the edit
// mode, blink flag, edited fields and a commit strobe. The unit takes one
// word per cycle while in_stall is low. An accepted word waits in the input
// register; when the core takes it, the state update is done in a single pass
// into the result register and raises out_valid. A result held by out_stall
// holds the input register, which then raises in_stall until the result is
// taken. blink_period may be written only while no word is in flight.
module clock_date_time_setting_fsm_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       key_valid,
	input  logic [3:0] key_code,
	input  logic [5:0] now_sec,
	input  logic [5:0] now_min,
	input  logic [4:0] now_hour,
	input  logic [4:0] now_day,
	input  logic [3:0] now_month,
	input  logic [7:0] now_year,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] mode,
	output logic       blink_on,
	output logic [5:0] edit_sec,
	output logic [5:0] edit_min,
	output logic [4:0] edit_hour,
	output logic [4:0] edit_day,
	output logic [3:0] edit_month,
	output logic [7:0] edit_year,
	output logic       commit
);

	cdts_pkg::item_t   item;
	cdts_pkg::item_t   item_s1;
	cdts_pkg::result_t res;
	logic              valid_s1;
	logic              take;

	assign item.key_valid = key_valid;
	assign item.key_code  = key_code;
	assign item.now_sec   = now_sec;
	assign item.now_min   = now_min;
	assign item.now_hour  = now_hour;
	assign item.now_day   = now_day;
	assign item.now_month = now_month;
	assign item.now_year  = now_year;

	cdts_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cdts_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res)
	);

	assign mode       = res.mode;
	assign blink_on   = res.blink_on;
	assign edit_sec   = res.edit_sec;
	assign edit_min   = res.edit_min;
	assign edit_hour  = res.edit_hour;
	assign edit_day   = res.edit_day;
	assign edit_month = res.edit_month;
	assign edit_year  = res.edit_year;
	assign commit     = res.commit;

endmodule
